/* hdl/spf_pkg.sv */
// Shared types, constants and helpers for the serial peripheral framer.
// Used by spf_ctrl, spf_dp and sio_peripheral_framer_top; no dependencies.
package spf_pkg;

    // Frame and store sizes (store depths must be powers of two)
    localparam int COMMAND_BYTES  = 5;
    localparam int FRAME_HDR      = COMMAND_BYTES - 1;
    localparam int PAYLOAD_DEPTH  = 4096;
    localparam int RESPONSE_DEPTH = 4096;
    localparam int OUTPUT_DEPTH   = 8192;
    localparam int REQUEST_DEPTH  = 4096;

    localparam int PAY_AW  = $clog2(PAYLOAD_DEPTH);
    localparam int RESP_AW = $clog2(RESPONSE_DEPTH);
    localparam int OUT_AW  = $clog2(OUTPUT_DEPTH);
    localparam int REQ_AW  = $clog2(REQUEST_DEPTH);

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    typedef enum logic [1:0] {
        KIND_HOST     = 2'd0,
        KIND_RESP     = 2'd1,
        KIND_PULL_OUT = 2'd2,
        KIND_PULL_REQ = 2'd3
    } kind_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_DEVICE   = 3'd0,
        CFG_WRITE_OP = 3'd1,
        CFG_READ_OP  = 3'd2,
        CFG_READ_LEN = 3'd3,
        CFG_ACK      = 3'd4,
        CFG_NAK      = 3'd5,
        CFG_COMPLETE = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_COMMAND  = 2'd0,
        PH_PAYLOAD  = 2'd1,
        PH_CHECKSUM = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PULL,
        ST_XCPL,
        ST_XDAT,
        ST_XSUM,
        ST_CPL,
        ST_COPY
    } state_t;

    typedef enum logic [2:0] {
        OSEL_ACK,
        OSEL_NAK,
        OSEL_CPL,
        OSEL_XDAT,
        OSEL_XSUM
    } osel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic  frame_store;
        logic  frame_clear;
        logic  load_write;
        logic  arm_read;
        logic  pay_store;
        logic  out_push;
        osel_t out_sel;
        logic  resp_push;
        logic  xfer_start;
        logic  xfer_step;
        logic  xfer_done;
        logic  copy_start;
        logic  copy_step;
        logic  pull;
        logic  pull_req;
        logic  out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic frame_full;
        logic dev_ok;
        logic sum_ok;
        logic is_wr;
        logic is_rd;
        logic aux_zero;
        logic arm_nz;
        logic pay_ok;
        logic rem_one;
        logic pending_nz;
        logic resp_nz;
        logic xfer_last;
        logic copy_empty;
        logic copy_last;
        logic out_busy;
    } dp_stat_t;

    // 8-bit add with end-around carry
    function automatic logic [7:0] csum_add(input logic [7:0] acc, input logic [7:0] v);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

/* hdl/spf_ctrl.sv */
// Controller state machine of the serial peripheral framer.
// Depends on spf_pkg; drives spf_dp through dp_cmd_t and reads dp_stat_t.
module spf_ctrl
    import spf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_kind,
    input  logic       in_last,
    output logic       in_ready,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   is_pull;
    logic   accept;

    assign is_pull  = (in_kind == KIND_PULL_OUT) || (in_kind == KIND_PULL_REQ);
    assign in_ready = (state_reg == ST_IDLE) && !(is_pull && stat.out_busy);
    assign accept   = in_valid && in_ready;

    // State and phase registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_COMMAND;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.out_sel = OSEL_ACK;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind_t'(in_kind))
                        KIND_HOST:
                        begin
                            unique case (phase_reg)
                                PH_PAYLOAD:
                                begin
                                    cmd.pay_store = 1'b1;
                                    if (stat.rem_one)
                                        phase_next = PH_CHECKSUM;
                                end
                                PH_CHECKSUM:
                                begin
                                    cmd.out_push = 1'b1;
                                    if (stat.pay_ok)
                                    begin
                                        cmd.out_sel = OSEL_ACK;
                                        state_next  = ST_CPL;
                                    end
                                    else
                                    begin
                                        cmd.out_sel     = OSEL_NAK;
                                        cmd.frame_clear = 1'b1;
                                        phase_next      = PH_COMMAND;
                                    end
                                end
                                default:
                                begin
                                    // Collect header; check device, sum, command
                                    if (!stat.frame_full)
                                        cmd.frame_store = 1'b1;
                                    else
                                    begin
                                        cmd.frame_clear = 1'b1;
                                        phase_next      = PH_COMMAND;
                                        if (stat.dev_ok)
                                        begin
                                            cmd.out_push = 1'b1;
                                            if (!stat.sum_ok)
                                                cmd.out_sel = OSEL_NAK;
                                            else if (stat.is_wr)
                                            begin
                                                cmd.load_write = 1'b1;
                                                phase_next = stat.aux_zero ? PH_CHECKSUM
                                                                           : PH_PAYLOAD;
                                            end
                                            else if (stat.is_rd)
                                            begin
                                                cmd.arm_read = 1'b1;
                                                if (stat.resp_nz && stat.arm_nz)
                                                    state_next = ST_XCPL;
                                            end
                                            else
                                                cmd.out_sel = OSEL_NAK;
                                        end
                                    end
                                end
                            endcase
                        end
                        KIND_RESP:
                        begin
                            cmd.resp_push = 1'b1;
                            if (in_last && stat.pending_nz)
                                state_next = ST_XCPL;
                        end
                        default:
                        begin
                            cmd.pull     = 1'b1;
                            cmd.pull_req = (in_kind == KIND_PULL_REQ);
                            state_next   = ST_PULL;
                        end
                    endcase
                end
            end
            ST_PULL:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_XCPL:
            begin
                cmd.out_push   = 1'b1;
                cmd.out_sel    = OSEL_CPL;
                cmd.xfer_start = 1'b1;
                state_next     = ST_XDAT;
            end
            ST_XDAT:
            begin
                cmd.out_push  = 1'b1;
                cmd.out_sel   = OSEL_XDAT;
                cmd.xfer_step = 1'b1;
                if (stat.xfer_last)
                    state_next = ST_XSUM;
            end
            ST_XSUM:
            begin
                cmd.out_push  = 1'b1;
                cmd.out_sel   = OSEL_XSUM;
                cmd.xfer_done = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CPL:
            begin
                cmd.out_push   = 1'b1;
                cmd.out_sel    = OSEL_CPL;
                cmd.copy_start = 1'b1;
                if (stat.copy_empty)
                begin
                    cmd.frame_clear = 1'b1;
                    phase_next      = PH_COMMAND;
                    state_next      = ST_IDLE;
                end
                else
                    state_next = ST_COPY;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (stat.copy_last)
                begin
                    cmd.frame_clear = 1'b1;
                    phase_next      = PH_COMMAND;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A transfer only starts with a nonzero armed length
    a_xfer_armed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_XCPL |-> stat.pending_nz)
        else $error("transfer started without armed length");

    // A pull state loads the output register, which is busy in the following cycle
    a_pull_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PULL |=> stat.out_busy)
        else $error("pull result not loaded");

    // A copy only runs in the checksum phase
    a_copy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY |-> phase_reg == PH_CHECKSUM)
        else $error("copy outside checksum phase");

endmodule

/* hdl/spf_dp.sv */
// Datapath of the serial peripheral framer: config registers, frame
// registers, payload store, response/output/request queues, output register.
// Depends on spf_pkg; commanded by spf_ctrl.
module spf_dp
    import spf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic [7:0]        in_data,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_data,
    output logic [1:0]        m_flags
);

    // Configuration
    logic [7:0]  dev_addr_reg, wr_op_reg, rd_op_reg, ack_reg, nak_reg, cpl_reg;
    logic [15:0] rd_len_reg;

    // Frame and write state
    logic [7:0]       fb_reg [4];
    logic [2:0]       frame_cnt_reg;
    logic [7:0]       frame_sum_reg;
    logic [15:0]      wr_rem_reg;
    logic [7:0]       pay_sum_reg;
    logic [PAY_AW:0]  pay_cnt_reg;
    logic [15:0]      pending_reg;
    logic             ovf_reg;

    // Queues
    logic [RESP_AW-1:0] resp_head_reg;
    logic [RESP_AW:0]   resp_cnt_reg;
    logic [OUT_AW-1:0]  out_head_reg;
    logic [OUT_AW:0]    out_cnt_reg;
    logic [REQ_AW-1:0]  req_head_reg;
    logic [REQ_AW:0]    req_cnt_reg;

    logic [7:0] pay_mem  [PAYLOAD_DEPTH];
    logic [7:0] resp_mem [RESPONSE_DEPTH];
    logic [7:0] out_mem  [OUTPUT_DEPTH];
    logic [7:0] req_mem  [REQUEST_DEPTH];
    logic [7:0] pay_rd, resp_rd, out_rd, req_rd;

    // Transfer and copy sequencing
    logic [15:0]     xi_reg;
    logic [7:0]      xsum_reg;
    logic [PAY_AW:0] cj_reg;

    // Pull and output register
    logic       pull_ok_reg, pull_req_reg, pull_ovf_reg;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic [1:0] m_flags_reg;

    logic [15:0]        aux;
    logic [7:0]         xdat;
    logic [7:0]         out_wval;
    logic               out_full, resp_full, req_full, pay_full;
    logic               out_drop, resp_drop, req_drop, pay_drop;
    logic [RESP_AW-1:0] resp_raddr;
    logic [PAY_AW-1:0]  pay_raddr;
    logic [PAY_AW:0]    cj_next;
    logic [16:0]        xi_inc;

    assign aux = {fb_reg[3], fb_reg[2]};
    assign xi_inc = {1'b0, xi_reg} + 17'd1;
    assign cj_next = cj_reg + {{PAY_AW{1'b0}}, 1'b1};
    assign xdat = ({1'b0, xi_reg} < {{(16 - RESP_AW){1'b0}}, resp_cnt_reg}) ? resp_rd : 8'd0;

    assign out_full  = (out_cnt_reg  == (OUT_AW + 1)'(OUTPUT_DEPTH));
    assign resp_full = (resp_cnt_reg == (RESP_AW + 1)'(RESPONSE_DEPTH));
    assign req_full  = (req_cnt_reg  == (REQ_AW + 1)'(REQUEST_DEPTH));
    assign pay_full  = (pay_cnt_reg  == (PAY_AW + 1)'(PAYLOAD_DEPTH));
    assign out_drop  = cmd.out_push && out_full;
    assign resp_drop = cmd.resp_push && resp_full;
    assign req_drop  = cmd.copy_step && req_full;
    assign pay_drop  = cmd.pay_store && pay_full;

    // Status toward the controller
    always_comb
    begin
        stat.frame_full = (frame_cnt_reg == 3'(FRAME_HDR));
        stat.dev_ok     = (fb_reg[0] == dev_addr_reg);
        stat.sum_ok     = (in_data == frame_sum_reg);
        stat.is_wr      = (fb_reg[1] == wr_op_reg);
        stat.is_rd      = (fb_reg[1] == rd_op_reg);
        stat.aux_zero   = (aux == 16'd0);
        stat.arm_nz     = (aux != 16'd0) || (rd_len_reg != 16'd0);
        stat.pay_ok     = (in_data == pay_sum_reg);
        stat.rem_one    = (wr_rem_reg <= 16'd1);
        stat.pending_nz = (pending_reg != 16'd0);
        stat.resp_nz    = (resp_cnt_reg != '0);
        stat.xfer_last  = (xi_inc[15:0] == pending_reg);
        stat.copy_empty = (pay_cnt_reg == '0);
        stat.copy_last  = (cj_next == pay_cnt_reg);
        stat.out_busy   = m_valid_reg;
    end

    // Select the byte pushed to the output queue
    always_comb
    begin
        unique case (cmd.out_sel)
            OSEL_ACK:  out_wval = ack_reg;
            OSEL_NAK:  out_wval = nak_reg;
            OSEL_CPL:  out_wval = cpl_reg;
            OSEL_XDAT: out_wval = xdat;
            OSEL_XSUM: out_wval = xsum_reg;
            default:   out_wval = 8'd0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= 8'd112;
            wr_op_reg    <= 8'd87;
            rd_op_reg    <= 8'd82;
            rd_len_reg   <= 16'd128;
            ack_reg      <= 8'd65;
            nak_reg      <= 8'd78;
            cpl_reg      <= 8'd67;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_DEVICE:   dev_addr_reg <= cfg_wdata[7:0];
                CFG_WRITE_OP: wr_op_reg    <= cfg_wdata[7:0];
                CFG_READ_OP:  rd_op_reg    <= cfg_wdata[7:0];
                CFG_READ_LEN: rd_len_reg   <= cfg_wdata;
                CFG_ACK:      ack_reg      <= cfg_wdata[7:0];
                CFG_NAK:      nak_reg      <= cfg_wdata[7:0];
                CFG_COMPLETE: cpl_reg      <= cfg_wdata[7:0];
                default:      ;
            endcase
        end
    end

    // Frame header byte registers (no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.frame_store)
            fb_reg[frame_cnt_reg[1:0]] <= in_data;
    end

    // Frame, write and read-arm control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= '0;
            frame_sum_reg <= '0;
            wr_rem_reg    <= '0;
            pay_sum_reg   <= '0;
            pay_cnt_reg   <= '0;
            pending_reg   <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.frame_store)
            begin
                frame_cnt_reg <= frame_cnt_reg + 3'd1;
                frame_sum_reg <= csum_add(frame_sum_reg, in_data);
            end
            if (cmd.pay_store)
            begin
                if (!pay_full)
                    pay_cnt_reg <= pay_cnt_reg + {{PAY_AW{1'b0}}, 1'b1};
                pay_sum_reg <= csum_add(pay_sum_reg, in_data);
                if (wr_rem_reg != 16'd0)
                    wr_rem_reg <= wr_rem_reg - 16'd1;
            end
            if (cmd.frame_clear)
            begin
                frame_cnt_reg <= '0;
                frame_sum_reg <= '0;
                wr_rem_reg    <= '0;
                pay_sum_reg   <= '0;
                pay_cnt_reg   <= '0;
            end
            if (cmd.load_write)
                wr_rem_reg <= aux;
            if (cmd.arm_read)
                pending_reg <= (aux == 16'd0) ? rd_len_reg : aux;
            if (cmd.xfer_done)
                pending_reg <= '0;
            // Sticky drop flag, cleared when a pull reports it
            if (cmd.pull)
                ovf_reg <= 1'b0;
            else if (out_drop || resp_drop || req_drop || pay_drop)
                ovf_reg <= 1'b1;
        end
    end

    // Response transfer and payload copy counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xi_reg   <= '0;
            xsum_reg <= '0;
            cj_reg   <= '0;
        end
        else
        begin
            if (cmd.xfer_start)
            begin
                xi_reg   <= '0;
                xsum_reg <= '0;
            end
            else if (cmd.xfer_step)
            begin
                xi_reg   <= xi_inc[15:0];
                xsum_reg <= csum_add(xsum_reg, xdat);
            end
            if (cmd.copy_start)
                cj_reg <= '0;
            else if (cmd.copy_step)
                cj_reg <= cj_next;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_head_reg <= '0;
            resp_cnt_reg  <= '0;
            out_head_reg  <= '0;
            out_cnt_reg   <= '0;
            req_head_reg  <= '0;
            req_cnt_reg   <= '0;
            pull_ok_reg   <= 1'b0;
            pull_req_reg  <= 1'b0;
            pull_ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.resp_push && !resp_full)
                resp_cnt_reg <= resp_cnt_reg + {{RESP_AW{1'b0}}, 1'b1};
            if (cmd.xfer_done)
            begin
                if ({{(16 - RESP_AW){1'b0}}, resp_cnt_reg} <= {1'b0, pending_reg})
                begin
                    resp_head_reg <= '0;
                    resp_cnt_reg  <= '0;
                end
                else
                begin
                    resp_head_reg <= resp_head_reg + pending_reg[RESP_AW-1:0];
                    resp_cnt_reg  <= resp_cnt_reg - (RESP_AW + 1)'(pending_reg);
                end
            end
            if (cmd.out_push && !out_full)
                out_cnt_reg <= out_cnt_reg + {{OUT_AW{1'b0}}, 1'b1};
            if (cmd.copy_step && !req_full)
                req_cnt_reg <= req_cnt_reg + {{REQ_AW{1'b0}}, 1'b1};
            // Pop at accept; data arrives from the registered read next cycle
            if (cmd.pull)
            begin
                pull_req_reg <= cmd.pull_req;
                pull_ovf_reg <= ovf_reg;
                if (cmd.pull_req)
                begin
                    pull_ok_reg <= (req_cnt_reg != '0);
                    if (req_cnt_reg != '0)
                    begin
                        req_head_reg <= req_head_reg + {{(REQ_AW - 1){1'b0}}, 1'b1};
                        req_cnt_reg  <= req_cnt_reg - {{REQ_AW{1'b0}}, 1'b1};
                    end
                end
                else
                begin
                    pull_ok_reg <= (out_cnt_reg != '0);
                    if (out_cnt_reg != '0)
                    begin
                        out_head_reg <= out_head_reg + {{(OUT_AW - 1){1'b0}}, 1'b1};
                        out_cnt_reg  <= out_cnt_reg - {{OUT_AW{1'b0}}, 1'b1};
                    end
                end
            end
        end
    end

    // Read addresses for transfer and copy walks
    assign resp_raddr = resp_head_reg + (cmd.xfer_start ? '0 : xi_inc[RESP_AW-1:0]);
    assign pay_raddr  = cmd.copy_start ? '0 : cj_next[PAY_AW-1:0];

    // Payload store
    always_ff @(posedge clk)
    begin
        if (cmd.pay_store && !pay_full)
            pay_mem[pay_cnt_reg[PAY_AW-1:0]] <= in_data;
        pay_rd <= pay_mem[pay_raddr];
    end

    // Response queue memory
    always_ff @(posedge clk)
    begin
        if (cmd.resp_push && !resp_full)
            resp_mem[resp_head_reg + resp_cnt_reg[RESP_AW-1:0]] <= in_data;
        resp_rd <= resp_mem[resp_raddr];
    end

    // Output queue memory
    always_ff @(posedge clk)
    begin
        if (cmd.out_push && !out_full)
            out_mem[out_head_reg + out_cnt_reg[OUT_AW-1:0]] <= out_wval;
        out_rd <= out_mem[out_head_reg];
    end

    // Request queue memory
    always_ff @(posedge clk)
    begin
        if (cmd.copy_step && !req_full)
            req_mem[req_head_reg + req_cnt_reg[REQ_AW-1:0]] <= pay_rd;
        req_rd <= req_mem[req_head_reg];
    end

    // Output register; holds until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.out_load)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_data_reg  <= pull_ok_reg ? (pull_req_reg ? req_rd : out_rd) : 8'd0;
            m_flags_reg <= {pull_ovf_reg, pull_ok_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_flags = m_flags_reg;

    a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= (OUT_AW + 1)'(OUTPUT_DEPTH))
        else $error("output queue count beyond depth");

    a_resp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        resp_cnt_reg <= (RESP_AW + 1)'(RESPONSE_DEPTH))
        else $error("response queue count beyond depth");

    a_pay_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pay_cnt_reg <= (PAY_AW + 1)'(PAYLOAD_DEPTH))
        else $error("payload count beyond depth");

endmodule

/* hdl/sio_peripheral_framer_top.sv */
// Channel   | Dir | Signals                        | Contents
// s_axis    | in  | s_tvalid s_tready s_tdata ...  | data; tuser kind; tlast chunk_end
// m_axis    | out | m_tvalid m_tready m_tdata ...  | byte_out; tuser byte_valid, overflow
// cfg       | in  | cfg_we cfg_addr cfg_wdata      | register index and value
//
// Host and response bytes are taken in idle; a pull reads its queue, then loads.
// A served read writes the complete byte, the data walk and the checksum, one output
// queue write per cycle; a good write commit writes the complete byte, then copies
// the payload, one store read per cycle. Reset is asynchronous; queues start empty.
// A pull waits while the output register still holds an untaken result.
// Top level of the serial peripheral framer; depends on spf_pkg, spf_ctrl, spf_dp.
module sio_peripheral_framer_top
    import spf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data
    input  logic [1:0]        s_tuser,   // [1:0] kind
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] byte_out
    output logic [1:0]        m_tuser,   // [0] byte_valid, [1] overflow
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    spf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_tdata),
        .m_flags   (m_tuser)
    );

endmodule

/* tb/sio_peripheral_framer_top_tb.sv */
// Self-checking testbench for the serial peripheral framer: command frames, writes, reads.
// Depends on spf_pkg and sio_peripheral_framer_top; predicts every pull result internally.
module sio_peripheral_framer_top_tb;
    import spf_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       ovf;
    } pull_result_t;

    // Behavioral copy of the framer that predicts each pull result
    class framer_scoreboard;
        logic [7:0]  dev_addr, wr_op, rd_op, ack_c, nak_c, cpl_c;
        logic [15:0] rd_len;
        phase_t      ph;
        logic [7:0]  hdr [4];
        int          hdr_cnt;
        int          wr_left;
        logic [7:0]  pay_sum;
        logic [7:0]  pay_mem [PAYLOAD_DEPTH];
        int          pay_cnt;
        int          armed_len;
        logic [7:0]  resp_q [$];
        logic [7:0]  out_q [$];
        logic [7:0]  req_q [$];
        bit          ovf;
        pull_result_t pending [$];
        int          errors;

        function new();
            dev_addr = 8'd112; wr_op = 8'd87; rd_op = 8'd82; rd_len = 16'd128;
            ack_c = 8'd65; nak_c = 8'd78; cpl_c = 8'd67;
            to_idle();
            armed_len = 0;
            ovf = 0;
            errors = 0;
        endfunction

        function logic [7:0] add_eac(logic [7:0] a, logic [7:0] b);
            logic [8:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[7:0] + {7'd0, s[8]};
        endfunction

        function void to_idle();
            ph = PH_COMMAND; hdr_cnt = 0; pay_cnt = 0; pay_sum = 8'd0; wr_left = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_DEVICE:   dev_addr = v[7:0];
                CFG_WRITE_OP: wr_op = v[7:0];
                CFG_READ_OP:  rd_op = v[7:0];
                CFG_READ_LEN: rd_len = v;
                CFG_ACK:      ack_c = v[7:0];
                CFG_NAK:      nak_c = v[7:0];
                CFG_COMPLETE: cpl_c = v[7:0];
                default: ;
            endcase
        endfunction

        function void push_out(logic [7:0] v);
            if (out_q.size() >= OUTPUT_DEPTH) ovf = 1; else out_q.insert(out_q.size(), v);
        endfunction

        function void serve_read();
            logic [7:0] s, v;
            int k;
            s = 8'd0;
            if (armed_len == 0 || resp_q.size() == 0) return;
            push_out(cpl_c);
            for (k = 0; k < armed_len; k++)
            begin
                v = (k < resp_q.size()) ? resp_q[k] : 8'd0;
                push_out(v);
                s = add_eac(s, v);
            end
            push_out(s);
            for (k = 0; k < armed_len && resp_q.size() > 0; k++) void'(resp_q.pop_front());
            armed_len = 0;
        endfunction

        function void close_frame(logic [7:0] got);
            logic [7:0] s;
            logic [15:0] aux;
            int k;
            s = 8'd0;
            if (hdr[0] != dev_addr)
            begin
                to_idle();
                return;
            end
            for (k = 0; k < 4; k++) s = add_eac(s, hdr[k]);
            aux = {hdr[3], hdr[2]};
            if (got != s)
            begin
                push_out(nak_c);
                to_idle();
            end
            else if (hdr[1] == wr_op)
            begin
                push_out(ack_c);
                to_idle();
                wr_left = int'(aux);
                ph = (aux == 0) ? PH_CHECKSUM : PH_PAYLOAD;
            end
            else if (hdr[1] == rd_op)
            begin
                push_out(ack_c);
                armed_len = (aux == 0) ? int'(rd_len) : int'(aux);
                to_idle();
                serve_read();
            end
            else
            begin
                push_out(nak_c);
                to_idle();
            end
        endfunction

        // Note one accepted input transfer
        function void note_input(kind_t kind, logic [7:0] d, logic last);
            int k;
            pull_result_t r;
            case (kind)
                KIND_HOST:
                begin
                    if (ph == PH_PAYLOAD)
                    begin
                        if (pay_cnt < PAYLOAD_DEPTH) pay_mem[pay_cnt++] = d; else ovf = 1;
                        pay_sum = add_eac(pay_sum, d);
                        if (wr_left > 0) wr_left--;
                        if (wr_left == 0) ph = PH_CHECKSUM;
                    end
                    else if (ph == PH_CHECKSUM)
                    begin
                        if (d != pay_sum) push_out(nak_c);
                        else
                        begin
                            push_out(ack_c);
                            push_out(cpl_c);
                            for (k = 0; k < pay_cnt; k++)
                                if (req_q.size() >= REQUEST_DEPTH) ovf = 1;
                                else req_q.insert(req_q.size(), pay_mem[k]);
                        end
                        to_idle();
                    end
                    else if (hdr_cnt < 4) hdr[hdr_cnt++] = d;
                    else close_frame(d);
                end
                KIND_RESP:
                begin
                    if (resp_q.size() >= RESPONSE_DEPTH) ovf = 1;
                    else resp_q.insert(resp_q.size(), d);
                    if (last) serve_read();
                end
                default:
                begin
                    if (kind == KIND_PULL_OUT)
                        r.valid = out_q.size() > 0;
                    else
                        r.valid = req_q.size() > 0;
                    r.value = !r.valid ? 8'd0 :
                              (kind == KIND_PULL_OUT) ? out_q.pop_front() : req_q.pop_front();
                    r.ovf = ovf;
                    ovf = 0;
                    pending.insert(pending.size(), r);
                end
            endcase
        endfunction

        // Check one accepted output transfer against the oldest prediction
        function void check_result(logic [7:0] d, logic [1:0] u);
            pull_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h/%b", $time, d, u);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d !== e.value || u[0] !== e.valid || u[1] !== e.ovf)
            begin
                $display("%0t: mismatch expected byte %h valid %b ovf %b actual %h %b %b",
                         $time, e.value, e.valid, e.ovf, d, u[0], u[1]);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0, s_tlast = 0, m_tready = 0, cfg_we = 0;
    logic [7:0] s_tdata = 0;
    logic [1:0] s_tuser = 0;
    logic m_tvalid, s_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic [CFG_AW-1:0] cfg_addr = 0;
    logic [CFG_DW-1:0] cfg_wdata = 0;

    framer_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_sink = 0;
    bit  calm = 0;
    localparam int CYCLE_LIMIT = 1500000;

    always #6 clk = ~clk;

    sio_peripheral_framer_top DUT (.*);

    // Sink: random stalls, a long hold-off on request
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= !hold_sink && (calm || $urandom_range(99) >= 14);
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sio_peripheral_framer_top regression: fail");
            $finish;
        end
    end

    // Offer one item; valid stays up after the transfer until the next item or quiet
    task automatic send(kind_t kind, logic [7:0] d, logic last);
        cfg_we <= 1'b0;
        while (!calm && $urandom_range(99) < 14)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1; s_tuser <= kind; s_tdata <= d; s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_input(kind, d, last);
    endtask

    // Drop input valid and configuration write enable
    task automatic quiet();
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
    endtask

    task automatic host(logic [7:0] d);
        send(KIND_HOST, d, 1'b0);
    endtask

    task automatic pull(kind_t k);
        send(k, 8'($urandom), 1'($urandom));
    endtask

    task automatic frame(logic [7:0] dev, logic [7:0] cmd, logic [15:0] aux, bit bad);
        logic [7:0] s;
        s = sb.add_eac(sb.add_eac(sb.add_eac(dev, cmd), aux[7:0]), aux[15:8]);
        host(dev); host(cmd); host(aux[7:0]); host(aux[15:8]);
        host(bad ? s ^ 8'h5a : s);
    endtask

    task automatic write_op(int n, bit bad);
        logic [7:0] s, v;
        s = 8'd0;
        frame(sb.dev_addr, sb.wr_op, 16'(n), 0);
        repeat (n)
        begin
            v = 8'($urandom);
            s = sb.add_eac(s, v);
            host(v);
        end
        host(bad ? s + 8'd1 : s);
    endtask

    task automatic respond(int n);
        repeat (n) send(KIND_RESP, 8'($urandom), 1'b0);
        send(KIND_RESP, 8'($urandom), 1'b1);
    endtask

    task automatic drain_all();
        while (sb.out_q.size() > 0) pull(KIND_PULL_OUT);
        while (sb.req_q.size() > 0) pull(KIND_PULL_REQ);
        pull(KIND_PULL_OUT);
        quiet();
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write enable stays up until the next item or quiet
    task automatic set_reg(cfg_idx_t idx, logic [15:0] v);
        cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 30) write_op($urandom_range(8), $urandom_range(9) == 0);
        else if (r < 45) frame(sb.dev_addr, sb.rd_op, 16'($urandom_range(6)),
                               $urandom_range(9) == 0);
        else if (r < 55) respond($urandom_range(5));
        else if (r < 60) host(8'($urandom));
        else if (r < 63) frame(8'($urandom), 8'($urandom), 16'($urandom), 0);
        else if (r < 85) pull(KIND_PULL_OUT);
        else pull(KIND_PULL_REQ);
    endtask

    initial
    begin
        int phase_no;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty pulls, every operation, special cases
        pull(KIND_PULL_OUT); pull(KIND_PULL_REQ);
        frame(8'd3, sb.wr_op, 16'd1, 0);           // wrong device
        frame(sb.dev_addr, sb.wr_op, 16'd1, 1);    // bad frame checksum
        frame(sb.dev_addr, 8'd0, 16'd0, 0);        // unknown command
        write_op(0, 0);                            // zero length write
        write_op(3, 1);                            // bad payload checksum
        write_op(2, 0);
        frame(sb.dev_addr, sb.rd_op, 16'd4, 0);
        send(KIND_RESP, 8'hff, 1'b0);              // no chunk end, no start
        send(KIND_RESP, 8'h00, 1'b1);              // short response, padded
        frame(sb.dev_addr, sb.rd_op, 16'd0, 0);    // default length
        drain_all();

        // Configuration phases, extremes included
        set_reg(CFG_WRITE_OP, 16'd9); set_reg(CFG_READ_OP, 16'd9);   // equal opcodes
        set_reg(CFG_DEVICE, 16'd255); set_reg(CFG_READ_LEN, 16'd0);
        set_reg(CFG_ACK, 16'd0); set_reg(CFG_NAK, 16'd255); set_reg(CFG_COMPLETE, 16'd0);
        write_op(1, 0);
        drain_all();
        set_reg(CFG_READ_OP, 16'd255);
        frame(8'd255, 8'd255, 16'd0, 0);           // default length zero: arms nothing
        respond(1);
        drain_all();

        // Receiver hold-off: stall pulls behind the held output register, then wait for all results
        hold_sink = 1;
        set_reg(CFG_DEVICE, 16'd0); set_reg(CFG_READ_LEN, 16'd1);
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_sink = 0;
            end
            begin
                repeat (40) pull(KIND_PULL_OUT);
                repeat (8) write_op(3, 0);
            end
        join
        drain_all();

        set_reg(CFG_READ_LEN, 16'd65535);
        frame(8'd0, 8'd255, 16'd3, 0); respond(2);
        drain_all();

        for (phase_no = 0; phase_no < 3; phase_no++)
        begin
            set_reg(CFG_DEVICE, 16'($urandom)); set_reg(CFG_WRITE_OP, 16'd87);
            set_reg(CFG_READ_OP, 16'd82); set_reg(CFG_READ_LEN, 16'($urandom_range(1, 8)));
            set_reg(CFG_ACK, 16'($urandom)); set_reg(CFG_NAK, 16'($urandom));
            set_reg(CFG_COMPLETE, 16'($urandom));
            calm = (phase_no == 1);
            repeat (45) random_item();
            drain_all();
        end
        calm = 0;

        while (sb.pending.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("sio_peripheral_framer_top regression: pass");
        else
            $display("sio_peripheral_framer_top regression: fail");
        $finish;
    end
endmodule

/* sim.f */
hdl/spf_pkg.sv
hdl/spf_ctrl.sv
hdl/spf_dp.sv
hdl/sio_peripheral_framer_top.sv
tb/sio_peripheral_framer_top_tb.sv
